// ===== hdl/fec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fec_pkg
// Shared types, constants and a mod-255 helper for the frame encoder.
// ----------------------------------------------------------------------------
package fec_pkg;

  localparam int BYTE_W = 8;
  localparam int HDR_BYTES = 10;
  localparam int CTR_W = 4;

  localparam logic OP_HDR = 1'b0;
  localparam logic OP_PAY = 1'b1;

  localparam logic [BYTE_W-1:0] SUM_A_INIT = 8'hAA;
  localparam logic [BYTE_W-1:0] SUM_B_INIT = 8'h00;
  localparam logic [BYTE_W:0] MOD_BASE = 9'd255;

  typedef logic [BYTE_W-1:0] byte_t;

  // control from the serializer to the checksum unit
  typedef struct packed {
    logic  fold;     // a data byte goes out this cycle
    byte_t data;
    logic  clear;    // high check byte goes out, frame closes
    logic  restart;  // a header is taken, new frame starts
  } sum_ctl_t;

  // (a + b) mod 255 for a < 255, b <= 255
  function automatic byte_t add_mod255(input byte_t a, input byte_t b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MOD_BASE) begin
      s = s - MOD_BASE;
    end
    return s[BYTE_W-1:0];
  endfunction

endpackage

// ===== hdl/fec_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fec_in_if / fec_out_if
// Valid/ready channels for header and payload items and for frame bytes.
// ----------------------------------------------------------------------------
interface fec_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  destination;
  logic [7:0]  src_addr;
  logic [7:0]  subnet_id;
  logic [7:0]  send_mode;
  logic [15:0] send_params;
  logic [7:0]  node_kind;
  logic [7:0]  msg_kind;
  logic [7:0]  packet_seq;
  logic [7:0]  payload_len;
  logic [7:0]  payload_byte;

  modport source (
    output valid, op, destination, src_addr, subnet_id, send_mode, send_params,
           node_kind, msg_kind, packet_seq, payload_len, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, op, destination, src_addr, subnet_id, send_mode, send_params,
           node_kind, msg_kind, packet_seq, payload_len, payload_byte,
    output ready
  );
endinterface

interface fec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink (input valid, out_byte, frame_end, output ready);
endinterface

// ===== hdl/fec_fletcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fec_fletcher
// Running mod-255 Fletcher sums and the two check bytes of the open frame.
// ----------------------------------------------------------------------------
module fec_fletcher (
  input  logic              clk,
  input  logic              rst_n,
  input  fec_pkg::sum_ctl_t ctl,
  output fec_pkg::byte_t    chk_lo,
  output fec_pkg::byte_t    chk_hi
);

  fec_pkg::byte_t sum_a_r, sum_a_nxt;
  fec_pkg::byte_t sum_b_r, sum_b_nxt;
  fec_pkg::byte_t a_fold;

  assign a_fold = fec_pkg::add_mod255(sum_a_r, ctl.data);

  // hi byte is formed while the sums still hold their pre-check values
  assign chk_lo = 8'hFF - fec_pkg::add_mod255(sum_a_r, sum_b_r);
  assign chk_hi = 8'hFF - fec_pkg::add_mod255(sum_a_r, chk_lo);

  always_comb begin
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    if (ctl.restart || ctl.clear) begin
      sum_a_nxt = fec_pkg::SUM_A_INIT;
      sum_b_nxt = fec_pkg::SUM_B_INIT;
    end else if (ctl.fold) begin
      sum_a_nxt = a_fold;
      sum_b_nxt = fec_pkg::add_mod255(sum_b_r, a_fold);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_a_r <= fec_pkg::SUM_A_INIT;
      sum_b_r <= fec_pkg::SUM_B_INIT;
    end else begin
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
    end
  end

endmodule

// ===== hdl/frame_encoder_fletcher_checksum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_encoder_fletcher_checksum
// Serializes header and payload items into frame bytes with a mod-255
// Fletcher check pair closing each frame.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    op, header fields, payload_byte
//  out_ch    out   valid / ready    out_byte, frame_end
//
//  one frame byte leaves per cycle while the output is not stalled: a header
//  item sends 10 bytes (12 with an empty payload), a payload item 1 (3 on
//  the frame's last byte), a dropped payload item none.
//  the next item is taken in the cycle the current one sends its last byte.
//  reset closes any frame and returns the sums to 0xaa and 0.
//  a stalled output holds its beat in the output register and stops the
//  serializer; the input side waits only while the serializer is busy.
// ----------------------------------------------------------------------------
module frame_encoder_fletcher_checksum (
  input logic          clk,
  input logic          rst_n,
  fec_in_if.sink       in_ch,
  fec_out_if.source    out_ch
);

  logic                         act_r;
  logic                         hdr_r;
  logic                         chk_r;
  logic [fec_pkg::CTR_W-1:0]    ctr_r;
  logic [fec_pkg::CTR_W-1:0]    last_r;
  fec_pkg::byte_t               left_r;
  fec_pkg::byte_t               bytes_r [fec_pkg::HDR_BYTES];

  logic                         out_valid_r;
  fec_pkg::byte_t               out_byte_r;
  logic                         out_end_r;

  logic [fec_pkg::CTR_W-1:0]    n_data;
  logic                         is_data;
  logic                         is_lo;
  logic                         is_hi;
  logic                         emit;
  logic                         last;
  logic                         load;
  logic                         ld_hdr;
  logic                         ld_pay;
  fec_pkg::byte_t               cur_byte;
  fec_pkg::byte_t               chk_lo;
  fec_pkg::byte_t               chk_hi;
  fec_pkg::sum_ctl_t            sum_ctl;

  assign n_data  = hdr_r ? fec_pkg::CTR_W'(fec_pkg::HDR_BYTES) : fec_pkg::CTR_W'(1);
  assign is_data = ctr_r < n_data;
  assign is_lo   = chk_r && (ctr_r == n_data);
  assign is_hi   = chk_r && (ctr_r == n_data + fec_pkg::CTR_W'(1));
  assign emit    = act_r && (!out_valid_r || out_ch.ready);
  assign last    = ctr_r == last_r;

  assign in_ch.ready = !act_r || (emit && last);
  assign load   = in_ch.valid && in_ch.ready;
  assign ld_hdr = load && (in_ch.op == fec_pkg::OP_HDR);
  // payload with no open frame is consumed and dropped
  assign ld_pay = load && (in_ch.op == fec_pkg::OP_PAY) && (left_r != 8'd0);

  always_comb begin
    if (is_data) begin
      cur_byte = bytes_r[ctr_r];
    end else if (is_lo) begin
      cur_byte = chk_lo;
    end else begin
      cur_byte = chk_hi;
    end
  end

  assign sum_ctl.fold    = emit && is_data;
  assign sum_ctl.data    = cur_byte;
  assign sum_ctl.clear   = emit && is_hi;
  assign sum_ctl.restart = ld_hdr;

  fec_fletcher u_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (sum_ctl),
    .chk_lo (chk_lo),
    .chk_hi (chk_hi)
  );

  // serializer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      hdr_r  <= 1'b0;
      chk_r  <= 1'b0;
      ctr_r  <= '0;
      last_r <= '0;
      left_r <= 8'd0;
    end else begin
      if (emit) begin
        ctr_r <= ctr_r + fec_pkg::CTR_W'(1);
        if (last) begin
          act_r <= 1'b0;
        end
      end
      if (ld_hdr) begin
        act_r  <= 1'b1;
        hdr_r  <= 1'b1;
        ctr_r  <= '0;
        chk_r  <= (in_ch.payload_len == 8'd0);
        last_r <= (in_ch.payload_len == 8'd0) ?
                  fec_pkg::CTR_W'(fec_pkg::HDR_BYTES + 1) :
                  fec_pkg::CTR_W'(fec_pkg::HDR_BYTES - 1);
        left_r <= in_ch.payload_len;
      end else if (ld_pay) begin
        act_r  <= 1'b1;
        hdr_r  <= 1'b0;
        ctr_r  <= '0;
        chk_r  <= (left_r == 8'd1);
        last_r <= (left_r == 8'd1) ? fec_pkg::CTR_W'(2) : fec_pkg::CTR_W'(0);
        left_r <= left_r - 8'd1;
      end
    end
  end

  // item bytes, header order
  always_ff @(posedge clk) begin
    if (ld_hdr) begin
      bytes_r[0] <= in_ch.destination;
      bytes_r[1] <= in_ch.src_addr;
      bytes_r[2] <= in_ch.subnet_id;
      bytes_r[3] <= in_ch.send_mode;
      bytes_r[4] <= in_ch.send_params[7:0];
      bytes_r[5] <= in_ch.send_params[15:8];
      bytes_r[6] <= in_ch.node_kind;
      bytes_r[7] <= in_ch.msg_kind;
      bytes_r[8] <= in_ch.packet_seq;
      bytes_r[9] <= in_ch.payload_len;
    end else if (ld_pay) begin
      bytes_r[0] <= in_ch.payload_byte;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= cur_byte;
      out_end_r  <= is_hi;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.frame_end = out_end_r;

endmodule

// ===== verif/frame_byte_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_byte_monitor
// Watches the item and frame byte channels of the frame encoder. For every
// item taken it works out the frame bytes it owes, with the mod-255 check
// pair when the item closes a frame. It then compares each frame byte that
// leaves against the oldest byte still owed.
// ----------------------------------------------------------------------------
module frame_byte_monitor (
  input  logic clk,
  input  logic rst_n,
  fec_in_if    in_mon,
  fec_out_if   out_mon,
  output int   mismatch_count,
  output int   bytes_owed,
  output int   bytes_checked,
  output int   frames_closed,
  output int   items_taken,
  output int   dropped_items
);

  localparam int OWED_DEPTH = 1024;

  typedef struct packed {
    fec_pkg::byte_t data;
    logic           last;
  } frame_beat_t;

  // ring of beats still owed, oldest at owed_rd
  frame_beat_t    owed_mem [OWED_DEPTH];
  int             owed_wr;
  int             owed_rd;
  frame_beat_t    due;
  fec_pkg::byte_t run_a;
  fec_pkg::byte_t run_b;
  fec_pkg::byte_t left_cnt;

  function automatic fec_pkg::byte_t mod255_sum(input fec_pkg::byte_t x,
                                                input fec_pkg::byte_t y);
    return fec_pkg::byte_t'((int'(x) + int'(y)) % 255);
  endfunction

  function automatic void owe_beat(input fec_pkg::byte_t b, input logic end_flag);
    if (owed_wr - owed_rd >= OWED_DEPTH) begin
      $display("%0t: owed beat store overflow", $time);
      mismatch_count++;
    end else begin
      owed_mem[owed_wr % OWED_DEPTH] = '{data: b, last: end_flag};
      owed_wr++;
    end
  endfunction

  function automatic void add_data(input fec_pkg::byte_t b);
    run_a = mod255_sum(run_a, b);
    run_b = mod255_sum(run_b, run_a);
    owe_beat(b, 1'b0);
  endfunction

  function automatic void close_frame();
    fec_pkg::byte_t lo;
    fec_pkg::byte_t hi;
    lo = fec_pkg::byte_t'(255 - int'(mod255_sum(run_a, run_b)));
    hi = fec_pkg::byte_t'(255 - int'(mod255_sum(run_a, lo)));
    owe_beat(lo, 1'b0);
    owe_beat(hi, 1'b1);
    run_a    = fec_pkg::SUM_A_INIT;
    run_b    = fec_pkg::SUM_B_INIT;
    left_cnt = '0;
  endfunction

  function automatic void encode_item();
    if (in_mon.op == fec_pkg::OP_HDR) begin
      // a new header drops whatever frame was open
      run_a = fec_pkg::SUM_A_INIT;
      run_b = fec_pkg::SUM_B_INIT;
      add_data(in_mon.destination);
      add_data(in_mon.src_addr);
      add_data(in_mon.subnet_id);
      add_data(in_mon.send_mode);
      add_data(in_mon.send_params[7:0]);
      add_data(in_mon.send_params[15:8]);
      add_data(in_mon.node_kind);
      add_data(in_mon.msg_kind);
      add_data(in_mon.packet_seq);
      add_data(in_mon.payload_len);
      left_cnt = in_mon.payload_len;
      if (left_cnt == 8'd0) begin
        close_frame();
      end
    end else if (left_cnt == 8'd0) begin
      dropped_items++;
    end else begin
      add_data(in_mon.payload_byte);
      left_cnt--;
      if (left_cnt == 8'd0) begin
        close_frame();
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_wr        = 0;
      owed_rd        = 0;
      run_a          = fec_pkg::SUM_A_INIT;
      run_b          = fec_pkg::SUM_B_INIT;
      left_cnt       = '0;
      mismatch_count = 0;
      bytes_owed     = 0;
      bytes_checked  = 0;
      frames_closed  = 0;
      items_taken    = 0;
      dropped_items  = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        items_taken++;
        encode_item();
      end
      if (out_mon.valid && out_mon.ready) begin
        if (owed_wr == owed_rd) begin
          $display("%0t: unexpected frame byte %02h (frame_end %0b), nothing owed",
                   $time, out_mon.out_byte, out_mon.frame_end);
          mismatch_count++;
        end else begin
          due = owed_mem[owed_rd % OWED_DEPTH];
          owed_rd++;
          bytes_checked++;
          if (out_mon.out_byte !== due.data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, due.data, out_mon.out_byte);
            mismatch_count++;
          end
          if (out_mon.frame_end !== due.last) begin
            $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                     $time, due.last, out_mon.frame_end);
            mismatch_count++;
          end
          if (due.last) begin
            frames_closed++;
          end
        end
      end
      bytes_owed = owed_wr - owed_rd;
    end
  end

endmodule

// ===== verif/frame_encoder_fletcher_checksum_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_encoder_fletcher_checksum_tb
// Drives header and payload items into the frame encoder. A directed opening
// covers field extremes, empty and short frames, dropped payload bytes and
// abandoned frames. Random frames follow under three idling mixes and one
// long output hold-off. Checking is done by frame_byte_monitor.
// ----------------------------------------------------------------------------
module frame_encoder_fletcher_checksum_tb;

  // worst run is far below this: ~400 items, up to 12 beats each, under
  // the heaviest receiver idling, plus the hold-off
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic           op;
    fec_pkg::byte_t destination;
    fec_pkg::byte_t source;
    fec_pkg::byte_t subnet_id;
    fec_pkg::byte_t send_mode;
    logic [15:0]    send_params;
    fec_pkg::byte_t node_kind;
    fec_pkg::byte_t msg_kind;
    fec_pkg::byte_t packet_seq;
    fec_pkg::byte_t payload_len;
    fec_pkg::byte_t payload_byte;
  } enc_item_t;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_req;
  logic hold_served;
  int   cycle_count = 0;
  int   mismatch_count;
  int   bytes_owed;
  int   bytes_checked;
  int   frames_closed;
  int   items_taken;
  int   dropped_items;

  fec_in_if  in_ch ();
  fec_out_if out_ch ();

  frame_encoder_fletcher_checksum dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_byte_monitor u_frame_mon (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .bytes_owed     (bytes_owed),
    .bytes_checked  (bytes_checked),
    .frames_closed  (frames_closed),
    .items_taken    (items_taken),
    .dropped_items  (dropped_items)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d frame bytes still owed", $time, bytes_owed);
      $display("frame_encoder_fletcher_checksum_tb: FAIL");
      $finish;
    end
  end

  // receiver: random ready, and one long hold-off once requested
  initial begin
    out_ch.ready = 1'b0;
    hold_served  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_served  = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready = rst_n && (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  function automatic enc_item_t header_item(input fec_pkg::byte_t len);
    enc_item_t it;
    it.op           = fec_pkg::OP_HDR;
    it.destination  = fec_pkg::byte_t'($urandom);
    it.source       = fec_pkg::byte_t'($urandom);
    it.subnet_id    = fec_pkg::byte_t'($urandom);
    it.send_mode    = fec_pkg::byte_t'($urandom);
    it.send_params  = 16'($urandom);
    it.node_kind    = fec_pkg::byte_t'($urandom);
    it.msg_kind     = fec_pkg::byte_t'($urandom);
    it.packet_seq   = fec_pkg::byte_t'($urandom);
    it.payload_len  = len;
    it.payload_byte = fec_pkg::byte_t'($urandom);
    return it;
  endfunction

  function automatic enc_item_t payload_item(input fec_pkg::byte_t b);
    enc_item_t it;
    it              = header_item(fec_pkg::byte_t'($urandom));
    it.op           = fec_pkg::OP_PAY;
    it.payload_byte = b;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_item(input enc_item_t it);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.op           = it.op;
    in_ch.destination  = it.destination;
    in_ch.src_addr     = it.source;
    in_ch.subnet_id    = it.subnet_id;
    in_ch.send_mode    = it.send_mode;
    in_ch.send_params  = it.send_params;
    in_ch.node_kind    = it.node_kind;
    in_ch.msg_kind     = it.msg_kind;
    in_ch.packet_seq   = it.packet_seq;
    in_ch.payload_len  = it.payload_len;
    in_ch.payload_byte = it.payload_byte;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // mostly whole frames, some cut short and some stray payload bytes
  task automatic random_frames(input int budget);
    int             taken;
    int             pick;
    int             n_pay;
    fec_pkg::byte_t len;
    taken = 0;
    while (taken < budget) begin
      pick = int'($urandom_range(99));
      if (pick < 6) begin
        send_item(payload_item(fec_pkg::byte_t'($urandom)));
        taken += 1;
      end else begin
        if ($urandom_range(15) == 0) begin
          len = fec_pkg::byte_t'($urandom_range(255, 9));
        end else begin
          len = fec_pkg::byte_t'($urandom_range(8, 0));
        end
        n_pay = int'(len);
        if (pick < 16 || len > 8'd24) begin
          n_pay = int'($urandom_range((len < 8'd12) ? int'(len) : 12, 0));
        end
        send_item(header_item(len));
        for (int k = 0; k < n_pay; k++) begin
          send_item(payload_item(fec_pkg::byte_t'($urandom)));
        end
        taken += 1 + n_pay;
      end
    end
  endtask

  initial begin
    enc_item_t it;
    hold_req           = 1'b0;
    send_idle_pct      = 38;
    recv_idle_pct      = 71;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = fec_pkg::OP_HDR;
    in_ch.destination  = '0;
    in_ch.src_addr     = '0;
    in_ch.subnet_id    = '0;
    in_ch.send_mode    = '0;
    in_ch.send_params  = '0;
    in_ch.node_kind    = '0;
    in_ch.msg_kind     = '0;
    in_ch.packet_seq   = '0;
    in_ch.payload_len  = '0;
    in_ch.payload_byte = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty frames with all-zero and all-one fields
    it = '0;
    it.op = fec_pkg::OP_HDR;
    send_item(it);
    it = '1;
    it.op = fec_pkg::OP_HDR;
    it.payload_len = '0;
    send_item(it);
    // payload with no frame open is dropped
    send_item(payload_item(8'h3c));
    send_item(header_item(8'd1));
    send_item(payload_item(8'h00));
    send_item(header_item(8'd2));
    send_item(payload_item(8'hff));
    send_item(payload_item(8'hff));
    // frames abandoned by a new header
    send_item(header_item(8'd3));
    send_item(payload_item(fec_pkg::byte_t'($urandom)));
    send_item(header_item(8'd0));
    it = '1;
    it.op = fec_pkg::OP_HDR;
    send_item(it);
    send_item(payload_item(8'ha5));
    send_item(payload_item(8'h5a));
    send_item(header_item(8'd1));
    send_item(payload_item(8'h80));
    send_item(payload_item(fec_pkg::byte_t'($urandom)));
    send_item(header_item(8'd4));
    send_item(payload_item(8'h00));
    send_item(payload_item(8'hff));
    send_item(payload_item(8'h01));
    send_item(payload_item(8'hfe));

    random_frames(125);
    send_idle_pct = 71;
    recv_idle_pct = 38;
    random_frames(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    random_frames(110);
    in_ch.valid = 1'b0;

    while (bytes_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("items taken %0d (dropped payload %0d), frame bytes checked %0d, frames closed %0d",
             items_taken, dropped_items, bytes_checked, frames_closed);
    $display("idle mixes 38/71, 71/38 and none, with a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("frame_encoder_fletcher_checksum_tb: PASS");
    end else begin
      $display("frame_encoder_fletcher_checksum_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== frame_encoder_fletcher_checksum.f =====
hdl/fec_pkg.sv
hdl/fec_if.sv
hdl/fec_fletcher.sv
hdl/frame_encoder_fletcher_checksum.sv
verif/frame_byte_monitor.sv
verif/frame_encoder_fletcher_checksum_tb.sv
